FILE: rtl/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants for the particle motion step block: Q16.16
// widths, the iterative root/divide unit request, register and mode codes.
// ----------------------------------------------------------------------------
package pms_pkg;

  // data widths
  localparam int unsigned QW       = 32;          // Q16.16 word
  localparam int unsigned TOP_W    = 31;          // top speed register
  localparam int unsigned MUL_W    = 33;          // shared multiplier operand
  localparam int unsigned PROD_W   = 2 * MUL_W;   // multiplier product
  localparam int unsigned RAD_W    = 2 * QW;      // radicand / dividend
  localparam int unsigned REM_W    = QW + 3;      // partial remainder
  localparam int unsigned CNT_W    = 6;           // iteration counter
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned AX_W     = 2;           // axis index

  // reciprocal of 3 scaled by 2^34, rounded up; exact for dividends below 2^33
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [MUL_W-1:0] RECIP3 = 33'h1_5555_5556;

  // iteration counts of the shared unit
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(QW - 1);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(RAD_W / 2);

  // register reset values
  localparam logic [TOP_W-1:0]     TOP_SPEED_RST   = 31'd655360;
  localparam logic signed [QW-1:0] UPPER_BOUND_RST = 32'sd9830400;
  localparam logic signed [QW-1:0] LOWER_BOUND_RST = -32'sd9830400;

  // saturation limits
  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // operation codes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_SPEED   = 2'd0,
    CFG_UPPER_BOUND = 2'd1,
    CFG_LOWER_BOUND = 2'd2,
    CFG_EDGE_MODE   = 2'd3
  } cfg_reg_e;

  // edge handling modes
  typedef enum logic [MODE_W-1:0] {
    EDGE_NONE   = 2'd0,
    EDGE_BOUNCE = 2'd1,
    EDGE_WRAP   = 2'd2
  } edge_mode_e;

  // shared root/divide unit
  typedef enum logic {
    ITER_SQRT = 1'b0,
    ITER_DIV  = 1'b1
  } iter_mode_e;

  typedef struct packed {
    logic       start;
    iter_mode_e mode;
  } iter_req_t;

endpackage

FILE: rtl/particle_motion_step.sv
// ----------------------------------------------------------------------------
// particle_motion_step
// Euler step of one particle in Q16.16 with a speed limit and edge handling.
// A load beat goes straight to the output register. A step updates velocity
// and position per axis, then with the speed limit acting a root and three
// divides on the shared restoring unit rescale velocity, then edges act.
// One item at a time: a new beat is taken once the last is handed on.
// Reset: position and velocity clear to zero, registers take their defaults.
// ----------------------------------------------------------------------------
module particle_motion_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pms_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pms_pkg::QW-1:0]                cfg_data_i,
  // input beat
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic signed [pms_pkg::QW-1:0]         force_x_i,
  input  logic signed [pms_pkg::QW-1:0]         force_y_i,
  input  logic signed [pms_pkg::QW-1:0]         force_z_i,
  input  logic signed [pms_pkg::QW-1:0]         load_pos_x_i,
  input  logic signed [pms_pkg::QW-1:0]         load_pos_y_i,
  input  logic signed [pms_pkg::QW-1:0]         load_pos_z_i,
  input  logic signed [pms_pkg::QW-1:0]         load_vel_x_i,
  input  logic signed [pms_pkg::QW-1:0]         load_vel_y_i,
  input  logic signed [pms_pkg::QW-1:0]         load_vel_z_i,
  // result beat
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pms_pkg::QW-1:0]         pos_x_o,
  output logic signed [pms_pkg::QW-1:0]         pos_y_o,
  output logic signed [pms_pkg::QW-1:0]         pos_z_o,
  output logic signed [pms_pkg::QW-1:0]         vel_x_o,
  output logic signed [pms_pkg::QW-1:0]         vel_y_o,
  output logic signed [pms_pkg::QW-1:0]         vel_z_o
);
  import pms_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0_0000_0000_0001,
    S_ACC   = 13'b0_0000_0000_0010,
    S_UPD   = 13'b0_0000_0000_0100,
    S_POS   = 13'b0_0000_0000_1000,
    S_SQ    = 13'b0_0000_0001_0000,
    S_SQACC = 13'b0_0000_0010_0000,
    S_CMP   = 13'b0_0000_0100_0000,
    S_SQRT  = 13'b0_0000_1000_0000,
    S_SCL   = 13'b0_0001_0000_0000,
    S_DIVST = 13'b0_0010_0000_0000,
    S_DIV   = 13'b0_0100_0000_0000,
    S_EDGE  = 13'b0_1000_0000_0000,
    S_DONE  = 13'b1_0000_0000_0000
  } state_e;

  // saturate a 34-bit sum to the Q16.16 range
  function automatic logic signed [QW-1:0] sat32(input logic [QW+1:0] v);
    logic signed [QW-1:0] r;
    if ((v[QW+1:QW-1] == 3'b000) || (v[QW+1:QW-1] == 3'b111)) begin
      r = v[QW-1:0];
    end else if (v[QW+1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  // negation that saturates at the top
  function automatic logic signed [QW-1:0] satneg(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    if (v == Q_MIN) begin
      r = Q_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic logic [QW-1:0] absv(input logic signed [QW-1:0] v);
    logic [QW-1:0] r;
    if (v[QW-1]) begin
      r = ~v + QW'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // control state
  state_e          state_q, state_d;
  logic [AX_W-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;

  // configuration registers
  logic [TOP_W-1:0]     top_speed_q, top_speed_d;
  logic signed [QW-1:0] upper_bound_q, upper_bound_d;
  logic signed [QW-1:0] lower_bound_q, lower_bound_d;
  logic [MODE_W-1:0]    edge_mode_q, edge_mode_d;

  // particle state, reset to zero
  logic signed [QW-1:0] pos_q [3];
  logic signed [QW-1:0] pos_d [3];
  logic signed [QW-1:0] vel_q [3];
  logic signed [QW-1:0] vel_d [3];

  // working registers
  logic signed [QW-1:0]   force_q [3];
  logic signed [QW-1:0]   force_d [3];
  logic [QW-1:0]          mag_q [3];
  logic [QW-1:0]          mag_d [3];
  logic [RAD_W-1:0]       sum_q, sum_d;
  logic [2*TOP_W-1:0]     topsq_q, topsq_d;
  logic [QW-1:0]          root_q, root_d;
  logic signed [QW-1:0]   out_pos_q [3];
  logic signed [QW-1:0]   out_pos_d [3];
  logic signed [QW-1:0]   out_vel_q [3];
  logic signed [QW-1:0]   out_vel_d [3];

  // shared units
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  iter_req_t         iter_req;
  logic [RAD_W-1:0]  iter_operand;
  logic              iter_done;
  logic [QW-1:0]     iter_result;

  // per-axis helpers
  logic [MUL_W-1:0]     f2_abs;
  logic [QW-1:0]        acc_mag;
  logic [QW+1:0]        acc_ext;
  logic [QW+1:0]        vsum, psum;
  logic [QW-1:0]        mag_sel;
  logic signed [QW-1:0] edge_p, edge_v, edge_p1, edge_v1;
  logic                 edge_gt, edge_lt;

  pms_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pms_iter u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (iter_req),
    .operand_i (iter_operand),
    .divisor_i (root_q),
    .done_o    (iter_done),
    .result_o  (iter_result)
  );

  // magnitude of twice the force and the signed acceleration from the product
  always_comb begin
    logic [QW+1:0] f2;
    f2      = {force_q[idx_q][QW-1], force_q[idx_q], 1'b0};
    f2_abs  = force_q[idx_q][QW-1] ? MUL_W'(~f2 + (QW+2)'(1)) : MUL_W'(f2);
    acc_mag = prod[PROD_W-1:RECIP_SHIFT];
    acc_ext = force_q[idx_q][QW-1] ? (~{2'b00, acc_mag} + (QW+2)'(1))
                                   : {2'b00, acc_mag};
    vsum    = {{2{vel_q[idx_q][QW-1]}}, vel_q[idx_q]} + acc_ext;
    psum    = {{2{pos_q[idx_q][QW-1]}}, pos_q[idx_q]}
            + {{2{vel_q[idx_q][QW-1]}}, vel_q[idx_q]};
  end

  // square operand: three speed magnitudes, then the top speed
  always_comb begin
    case (idx_q)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      2'd2:    mag_sel = mag_q[2];
      default: mag_sel = QW'(top_speed_q);
    endcase
  end

  // edge handling of one axis
  always_comb begin
    edge_p  = pos_q[idx_q];
    edge_v  = vel_q[idx_q];
    edge_p1 = edge_p;
    edge_v1 = edge_v;
    edge_gt = (pos_q[idx_q] > upper_bound_q);
    edge_lt = 1'b0;
    case (edge_mode_q)
      EDGE_BOUNCE: begin
        edge_p1 = edge_gt ? upper_bound_q : pos_q[idx_q];
        edge_v1 = edge_gt ? satneg(vel_q[idx_q]) : vel_q[idx_q];
        edge_lt = (edge_p1 < lower_bound_q);
        edge_p  = edge_lt ? lower_bound_q : edge_p1;
        edge_v  = edge_lt ? satneg(edge_v1) : edge_v1;
      end
      EDGE_WRAP: begin
        edge_p1 = edge_gt ? lower_bound_q : pos_q[idx_q];
        edge_lt = (edge_p1 < lower_bound_q);
        edge_p  = edge_lt ? upper_bound_q : edge_p1;
      end
      default: begin
        edge_p = pos_q[idx_q];
      end
    endcase
  end

  // configuration writes
  always_comb begin
    top_speed_d   = top_speed_q;
    upper_bound_d = upper_bound_q;
    lower_bound_d = lower_bound_q;
    edge_mode_d   = edge_mode_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOP_SPEED:   top_speed_d   = cfg_data_i[TOP_W-1:0];
        CFG_UPPER_BOUND: upper_bound_d = cfg_data_i;
        CFG_LOWER_BOUND: lower_bound_d = cfg_data_i;
        CFG_EDGE_MODE:   edge_mode_d   = cfg_data_i[MODE_W-1:0];
        default:         edge_mode_d   = edge_mode_q;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pos_d        = pos_q;
    vel_d        = vel_q;
    force_d      = force_q;
    mag_d        = mag_q;
    sum_d        = sum_q;
    topsq_d      = topsq_q;
    root_d       = root_q;
    out_pos_d    = out_pos_q;
    out_vel_d    = out_vel_q;
    mul_a        = '0;
    mul_b        = '0;
    iter_req     = '{start: 1'b0, mode: ITER_SQRT};
    iter_operand = sum_q;

    case (state_q)
      // take a beat
      S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OP_LOAD) begin
            pos_d[0] = load_pos_x_i;
            pos_d[1] = load_pos_y_i;
            pos_d[2] = load_pos_z_i;
            vel_d[0] = load_vel_x_i;
            vel_d[1] = load_vel_y_i;
            vel_d[2] = load_vel_z_i;
            state_d  = S_DONE;
          end else begin
            force_d[0] = force_x_i;
            force_d[1] = force_y_i;
            force_d[2] = force_z_i;
            idx_d      = '0;
            sum_d      = '0;
            state_d    = S_ACC;
          end
        end
      end
      // 2f / 3 by reciprocal
      S_ACC: begin
        mul_a   = f2_abs;
        mul_b   = RECIP3;
        state_d = S_UPD;
      end
      S_UPD: begin
        vel_d[idx_q] = sat32(vsum);
        state_d      = S_POS;
      end
      S_POS: begin
        pos_d[idx_q] = sat32(psum);
        mag_d[idx_q] = absv(vel_q[idx_q]);
        if (idx_q == AX_W'(2)) begin
          idx_d   = '0;
          state_d = S_SQ;
        end else begin
          idx_d   = idx_q + AX_W'(1);
          state_d = S_ACC;
        end
      end
      // squared speed and squared limit
      S_SQ: begin
        mul_a   = MUL_W'(mag_sel);
        mul_b   = MUL_W'(mag_sel);
        state_d = S_SQACC;
      end
      S_SQACC: begin
        if (idx_q == AX_W'(3)) begin
          topsq_d = prod[2*TOP_W-1:0];
          state_d = S_CMP;
        end else begin
          sum_d   = sum_q + prod[RAD_W-1:0];
          idx_d   = idx_q + AX_W'(1);
          state_d = S_SQ;
        end
      end
      S_CMP: begin
        idx_d = '0;
        if (sum_q > RAD_W'(topsq_q)) begin
          iter_req = '{start: 1'b1, mode: ITER_SQRT};
          state_d  = S_SQRT;
        end else begin
          state_d = S_EDGE;
        end
      end
      S_SQRT: begin
        if (iter_done) begin
          root_d  = iter_result;
          state_d = S_SCL;
        end
      end
      // |v| * top / root per axis
      S_SCL: begin
        mul_a   = MUL_W'(mag_q[idx_q]);
        mul_b   = MUL_W'(top_speed_q);
        state_d = S_DIVST;
      end
      S_DIVST: begin
        iter_req     = '{start: 1'b1, mode: ITER_DIV};
        iter_operand = prod[RAD_W-1:0];
        state_d      = S_DIV;
      end
      S_DIV: begin
        if (iter_done) begin
          if (vel_q[idx_q][QW-1]) begin
            vel_d[idx_q] = -{1'b0, iter_result[QW-2:0]};
          end else begin
            vel_d[idx_q] = {1'b0, iter_result[QW-2:0]};
          end
          if (idx_q == AX_W'(2)) begin
            idx_d   = '0;
            state_d = S_EDGE;
          end else begin
            idx_d   = idx_q + AX_W'(1);
            state_d = S_SCL;
          end
        end
      end
      S_EDGE: begin
        pos_d[idx_q] = edge_p;
        vel_d[idx_q] = edge_v;
        if (idx_q == AX_W'(2)) begin
          idx_d   = '0;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + AX_W'(1);
        end
      end
      // hand the new state to the output register
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_pos_d   = pos_q;
          out_vel_d   = vel_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
      top_speed_q   <= TOP_SPEED_RST;
      upper_bound_q <= UPPER_BOUND_RST;
      lower_bound_q <= LOWER_BOUND_RST;
      edge_mode_q   <= EDGE_BOUNCE;
      pos_q         <= '{default: '0};
      vel_q         <= '{default: '0};
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
      top_speed_q   <= top_speed_d;
      upper_bound_q <= upper_bound_d;
      lower_bound_q <= lower_bound_d;
      edge_mode_q   <= edge_mode_d;
      pos_q         <= pos_d;
      vel_q         <= vel_d;
    end
  end

  // working and output payload
  always_ff @(posedge clk_i) begin
    force_q   <= force_d;
    mag_q     <= mag_d;
    sum_q     <= sum_d;
    topsq_q   <= topsq_d;
    root_q    <= root_d;
    out_pos_q <= out_pos_d;
    out_vel_q <= out_vel_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_pos_q[0];
  assign pos_y_o     = out_pos_q[1];
  assign pos_z_o     = out_pos_q[2];
  assign vel_x_o     = out_vel_q[0];
  assign vel_y_o     = out_vel_q[1];
  assign vel_z_o     = out_vel_q[2];

endmodule

FILE: rtl/pms_mul.sv
// ----------------------------------------------------------------------------
// pms_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pms_mul (
  input  logic                        clk_i,
  input  logic [pms_pkg::MUL_W-1:0]   a_i,
  input  logic [pms_pkg::MUL_W-1:0]   b_i,
  output logic [pms_pkg::PROD_W-1:0]  prod_o
);
  import pms_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;

  // full width product
  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/pms_iter.sv
// ----------------------------------------------------------------------------
// pms_iter
// Shared restoring unit: integer square root of a 64-bit value (two bits a
// cycle) or division of a 62-bit value by a 32-bit divisor with a quotient
// known to fit 31 bits (one bit a cycle).
// ----------------------------------------------------------------------------
module pms_iter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pms_pkg::iter_req_t         req_i,
  input  logic [pms_pkg::RAD_W-1:0]  operand_i,
  input  logic [pms_pkg::QW-1:0]     divisor_i,
  output logic                       done_o,
  output logic [pms_pkg::QW-1:0]     result_o
);
  import pms_pkg::*;

  // control
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  iter_mode_e       mode_q, mode_d;

  // datapath
  logic [REM_W-1:0] rem_q, rem_d;
  logic [RAD_W-1:0] bits_q, bits_d;
  logic [QW-1:0]    res_q, res_d;
  logic [QW-1:0]    dvs_q, dvs_d;

  logic [REM_W-1:0] cand, trial, rem_step;
  logic [RAD_W-1:0] bits_step;
  logic             ge;

  // one trial subtraction
  always_comb begin
    if (mode_q == ITER_DIV) begin
      cand      = {rem_q[REM_W-2:0], bits_q[RAD_W-1]};
      trial     = {{(REM_W-QW){1'b0}}, dvs_q};
      bits_step = {bits_q[RAD_W-2:0], 1'b0};
    end else begin
      cand      = {rem_q[REM_W-3:0], bits_q[RAD_W-1:RAD_W-2]};
      trial     = {1'b0, res_q, 2'b01};
      bits_step = {bits_q[RAD_W-3:0], 2'b00};
    end
    ge       = (cand >= trial);
    rem_step = ge ? (cand - trial) : cand;
  end

  // sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    res_d  = res_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      res_d  = '0;
      dvs_d  = divisor_i;
      if (req_i.mode == ITER_DIV) begin
        // high part is already below the divisor
        rem_d  = REM_W'(operand_i[RAD_W-3:QW-1]);
        bits_d = {operand_i[QW-2:0], {(RAD_W-QW+1){1'b0}}};
        cnt_d  = DIV_STEPS;
      end else begin
        rem_d  = '0;
        bits_d = operand_i;
        cnt_d  = SQRT_STEPS;
      end
    end else if (busy_q) begin
      rem_d  = rem_step;
      bits_d = bits_step;
      res_d  = {res_q[QW-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= ITER_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    res_q  <= res_d;
    dvs_q  <= dvs_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the particle motion step block against a predictor kept in step with
// every accepted beat. Each result beat is compared field by field with
// the oldest prediction. Directed beats hit saturation, the speed limit,
// bounce, wrap, inverted bounds and the unused edge mode. Random phases
// then vary the registers while both sides stall at random, but for one steady phase.
// ----------------------------------------------------------------------------

typedef struct {
  logic              op;
  logic signed [31:0] frc  [3];
  logic signed [31:0] lpos [3];
  logic signed [31:0] lvel [3];
} particle_beat_t;

typedef struct {
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
} particle_state_t;

// clamp to the signed 32-bit range
function automatic logic signed [31:0] clamp_q(input longint v);
  if (v > longint'(pms_pkg::Q_MAX)) return pms_pkg::Q_MAX;
  if (v < longint'(pms_pkg::Q_MIN)) return pms_pkg::Q_MIN;
  return v[31:0];
endfunction

// predicts particle state and checks result beats in order
class motion_board;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [30:0]        top_q;
  logic signed [31:0] upper_q;
  logic signed [31:0] lower_q;
  logic [1:0]         mode_q;
  particle_state_t    predicted_q [$];
  int errors, n_loads, n_steps, n_limited, n_edges;

  function new();
    for (int i = 0; i < 3; i++) begin
      pos_q[i] = '0;
      vel_q[i] = '0;
    end
    top_q   = pms_pkg::TOP_SPEED_RST;
    upper_q = pms_pkg::UPPER_BOUND_RST;
    lower_q = pms_pkg::LOWER_BOUND_RST;
    mode_q  = pms_pkg::EDGE_BOUNCE;
  endfunction

  function int pending();
    return predicted_q.size();
  endfunction

  function void write_reg(input pms_pkg::cfg_reg_e idx, input logic [31:0] data);
    case (idx)
      pms_pkg::CFG_TOP_SPEED:   top_q   = data[30:0];
      pms_pkg::CFG_UPPER_BOUND: upper_q = data;
      pms_pkg::CFG_LOWER_BOUND: lower_q = data;
      pms_pkg::CFG_EDGE_MODE:   mode_q  = data[1:0];
      default: ;
    endcase
  endfunction

  // integer square root, floor
  function bit [63:0] root_floor(input bit [63:0] x);
    bit [63:0] rem, root, b;
    rem  = x;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem && b != 0) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  -= root + b;
        root  = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // scale velocity down to the top speed
  function void cap_speed();
    bit [63:0] mag [3];
    bit [63:0] sum, top64, m, q;
    longint v;
    sum   = 0;
    top64 = 64'(top_q);
    for (int i = 0; i < 3; i++) begin
      v      = vel_q[i];
      mag[i] = (v < 0) ? 64'(-v) : 64'(v);
      sum   += mag[i] * mag[i];
    end
    if (sum <= top64 * top64) return;
    m = root_floor(sum);
    if (m == 0) return;
    n_limited++;
    for (int i = 0; i < 3; i++) begin
      q        = (mag[i] * top64) / m;
      vel_q[i] = (vel_q[i] < 0) ? -32'(q) : 32'(q);
    end
  endfunction

  // bounce or wrap per axis, bounds tested upper first
  function void treat_edges();
    bit hit;
    hit = 0;
    for (int i = 0; i < 3; i++) begin
      if (mode_q == pms_pkg::EDGE_BOUNCE) begin
        if (pos_q[i] > upper_q) begin
          pos_q[i] = upper_q;
          vel_q[i] = clamp_q(-longint'(vel_q[i]));
          hit = 1;
        end
        if (pos_q[i] < lower_q) begin
          pos_q[i] = lower_q;
          vel_q[i] = clamp_q(-longint'(vel_q[i]));
          hit = 1;
        end
      end else if (mode_q == pms_pkg::EDGE_WRAP) begin
        if (pos_q[i] > upper_q) begin
          pos_q[i] = lower_q;
          hit = 1;
        end
        if (pos_q[i] < lower_q) begin
          pos_q[i] = upper_q;
          hit = 1;
        end
      end
    end
    if (hit) n_edges++;
  endfunction

  // advance the predicted state for one accepted input beat
  function void note_input(input particle_beat_t b);
    particle_state_t s;
    longint acc;
    if (b.op == pms_pkg::OP_LOAD) begin
      n_loads++;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] = b.lpos[i];
        vel_q[i] = b.lvel[i];
      end
    end else begin
      n_steps++;
      for (int i = 0; i < 3; i++) begin
        acc      = (2 * longint'(b.frc[i])) / 3;
        vel_q[i] = clamp_q(longint'(vel_q[i]) + acc);
        pos_q[i] = clamp_q(longint'(pos_q[i]) + longint'(vel_q[i]));
      end
      cap_speed();
      treat_edges();
    end
    for (int i = 0; i < 3; i++) begin
      s.pos[i] = pos_q[i];
      s.vel[i] = vel_q[i];
    end
    predicted_q.push_back(s);
  endfunction

  // compare one result beat with the oldest prediction
  function void check_result(input particle_state_t got);
    particle_state_t want;
    string axis [3];
    axis = '{"x", "y", "z"};
    if (predicted_q.size() == 0) begin
      $error("result beat with no prediction waiting");
      errors++;
      return;
    end
    want = predicted_q.pop_front();
    for (int i = 0; i < 3; i++) begin
      if (got.pos[i] !== want.pos[i]) begin
        $error("pos_%s mismatch: expected %0d, actual %0d", axis[i], want.pos[i], got.pos[i]);
        errors++;
      end
      if (got.vel[i] !== want.vel[i]) begin
        $error("vel_%s mismatch: expected %0d, actual %0d", axis[i], want.vel[i], got.vel[i]);
        errors++;
      end
    end
  endfunction
endclass

module testbench;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int IDLE_PCT        = 22;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pms_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pms_pkg::QW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic signed [31:0] force_x_i = '0, force_y_i = '0, force_z_i = '0;
  logic signed [31:0] load_pos_x_i = '0, load_pos_y_i = '0, load_pos_z_i = '0;
  logic signed [31:0] load_vel_x_i = '0, load_vel_y_i = '0, load_vel_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;

  motion_board board;
  logic        steady_q = 1'b0;   // no idling on either side while set
  logic [30:0] cur_top;
  logic signed [31:0] cur_up, cur_lo;
  int          n_settings = 0;

  particle_motion_step dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .operation_i,
    .force_x_i, .force_y_i, .force_z_i,
    .load_pos_x_i, .load_pos_y_i, .load_pos_z_i,
    .load_vel_x_i, .load_vel_y_i, .load_vel_z_i,
    .out_valid_o, .out_ready_i,
    .pos_x_o, .pos_y_o, .pos_z_o, .vel_x_o, .vel_y_o, .vel_z_o
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= steady_q || ($urandom_range(99) >= IDLE_PCT);
  end

  // result monitor
  always @(posedge clk_i) begin
    particle_state_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.pos = '{pos_x_o, pos_y_o, pos_z_o};
      got.vel = '{vel_x_o, vel_y_o, vel_z_o};
      board.check_result(got);
    end
  end

  // run time limit
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // extremes and corner words
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(7))
      0: return pms_pkg::Q_MAX;
      1: return pms_pkg::Q_MIN;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // value scaled to the current top speed, mostly moderate
  function automatic logic signed [31:0] pick_motion();
    int unsigned span;
    span = (cur_top > 31'd3000000) ? 3000000 : int'(cur_top) + 1;
    if ($urandom_range(99) < 20) return pick_word();
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  // position near one of the bounds or anywhere
  function automatic logic signed [31:0] pick_place();
    longint b;
    if ($urandom_range(99) < 25) return pick_word();
    b = $urandom_range(1) ? longint'(cur_up) : longint'(cur_lo);
    return clamp_q(b + longint'($urandom_range(400000)) - 200000);
  endfunction

  // write all four registers, block idle
  task automatic set_config(input logic [30:0] top, input logic signed [31:0] up,
                            input logic signed [31:0] lo, input logic [1:0] mode);
    logic [31:0] data [4];
    pms_pkg::cfg_reg_e idx [4];
    data = '{{1'($urandom_range(1)), top}, up, lo, {30'($urandom), mode}};
    idx  = '{pms_pkg::CFG_TOP_SPEED, pms_pkg::CFG_UPPER_BOUND,
             pms_pkg::CFG_LOWER_BOUND, pms_pkg::CFG_EDGE_MODE};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.write_reg(idx[i], data[i]);
    end
    cfg_valid_i <= 1'b0;
    cur_top = top;
    cur_up  = up;
    cur_lo  = lo;
    n_settings++;
  endtask

  // hold the input beat until accepted, then maybe idle
  task automatic send_beat(input particle_beat_t b);
    operation_i  <= b.op;
    force_x_i    <= b.frc[0];
    force_y_i    <= b.frc[1];
    force_z_i    <= b.frc[2];
    load_pos_x_i <= b.lpos[0];
    load_pos_y_i <= b.lpos[1];
    load_pos_z_i <= b.lpos[2];
    load_vel_x_i <= b.lvel[0];
    load_vel_y_i <= b.lvel[1];
    load_vel_z_i <= b.lvel[2];
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(b);
    if (!steady_q && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  // sender pauses until every predicted result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic do_load(input logic signed [31:0] px, py, pz, vx, vy, vz);
    particle_beat_t b;
    b.op   = pms_pkg::OP_LOAD;
    b.frc  = '{$urandom, $urandom, $urandom};
    b.lpos = '{px, py, pz};
    b.lvel = '{vx, vy, vz};
    send_beat(b);
  endtask

  task automatic do_step(input logic signed [31:0] fx, fy, fz);
    particle_beat_t b;
    b.op   = pms_pkg::OP_STEP;
    b.frc  = '{fx, fy, fz};
    b.lpos = '{$urandom, $urandom, $urandom};
    b.lvel = '{$urandom, $urandom, $urandom};
    send_beat(b);
  endtask

  // main sequence
  initial begin
    logic [30:0] top;
    logic signed [31:0] up, lo, t;
    logic [1:0] mode;
    board   = new();
    cur_top = pms_pkg::TOP_SPEED_RST;
    cur_up  = pms_pkg::UPPER_BOUND_RST;
    cur_lo  = pms_pkg::LOWER_BOUND_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: from rest, saturating force, truncated acceleration
    do_step(0, 0, 0);
    do_step(pms_pkg::Q_MAX, pms_pkg::Q_MIN, 0);
    do_step(3, -3, 1);
    do_load(pms_pkg::Q_MAX, pms_pkg::Q_MIN, 0, pms_pkg::Q_MIN, pms_pkg::Q_MAX, -1);
    do_step(0, 0, 0);
    // just past each bound, one axis exactly on it
    do_load(9830401, -9830401, 9830400, 65536, -65536, 0);
    do_step(0, 0, 0);
    drain();

    // zero top speed with wrap
    set_config(31'd0, pms_pkg::UPPER_BOUND_RST, pms_pkg::LOWER_BOUND_RST, pms_pkg::EDGE_WRAP);
    do_load(0, 0, 0, 1000, -1000, 5);
    do_step(300, -300, 0);
    do_load(9830400, -9830400, 0, 0, 0, 0);
    do_step(98304, -98304, 0);
    drain();

    // widest range, no edges
    set_config(31'h7FFF_FFFF, pms_pkg::Q_MAX, pms_pkg::Q_MIN, pms_pkg::EDGE_NONE);
    do_load(pms_pkg::Q_MAX, pms_pkg::Q_MIN, 0, pms_pkg::Q_MAX, pms_pkg::Q_MIN, 0);
    do_step(pms_pkg::Q_MAX, pms_pkg::Q_MIN, pms_pkg::Q_MAX);
    do_step(pms_pkg::Q_MIN, pms_pkg::Q_MAX, pms_pkg::Q_MIN);
    drain();

    // inverted bounds: the second test acts on the first one's outcome
    set_config(pms_pkg::TOP_SPEED_RST, -32'sd65536, 32'sd65536, pms_pkg::EDGE_BOUNCE);
    do_load(0, 131072, -131072, 100, 100, 100);
    do_step(0, 0, 0);
    drain();
    set_config(pms_pkg::TOP_SPEED_RST, -32'sd65536, 32'sd65536, pms_pkg::EDGE_WRAP);
    do_step(0, 0, 0);
    drain();

    // unused edge mode behaves as no edges
    set_config(pms_pkg::TOP_SPEED_RST, pms_pkg::UPPER_BOUND_RST, pms_pkg::LOWER_BOUND_RST,
               2'd3);
    do_load(pms_pkg::Q_MAX, pms_pkg::Q_MIN, 0, 0, 0, 0);
    do_step(0, 0, 0);

    // random phases, one register setting each
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case ($urandom_range(5))
        0: top = '0;
        1: top = 31'h7FFF_FFFF;
        2: top = 31'($urandom);
        default: top = 31'($urandom_range(40, 1) * 65536 + $urandom_range(65535));
      endcase
      case ($urandom_range(5))
        0: begin
          up = pms_pkg::Q_MAX;
          lo = pms_pkg::Q_MIN;
        end
        1: begin
          t  = $urandom_range(300) * 65536;
          lo = t;
          up = -t;
        end
        2: begin
          up = $urandom;
          lo = $urandom;
        end
        default: begin
          up = $urandom_range(300, 1) * 65536;
          lo = -($urandom_range(300, 1) * 65536);
        end
      endcase
      mode = (p < 4) ? 2'(p) : 2'($urandom_range(3));
      set_config(top, up, lo, mode);
      steady_q <= (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 2) drain();
        if ($urandom_range(99) < 12)
          do_load(pick_place(), pick_place(), pick_place(),
                  pick_motion(), pick_motion(), pick_motion());
        else
          do_step(pick_motion(), pick_motion(), pick_motion());
      end
      steady_q <= 1'b0;
    end

    // wait out the last results, then a little longer for strays
    drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d loads and %0d steps over %0d register settings",
             board.n_loads, board.n_steps, n_settings);
    $display("speed limit engaged %0d times, edges acted %0d times",
             board.n_limited, board.n_edges);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
